// ----- rtl/adp_pkg.sv -----
// Shared types, codes and constants for the ASCII decimal number parser.
// No dependencies; every other file of the block refers to this package.
package adp_pkg;

   localparam int MAX_DIGITS_DEF = 19;

   localparam int CHAR_W      = 8;
   localparam int KIND_W      = 4;
   localparam int STATUS_W    = 3;
   localparam int VALUE_W     = 64;
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   typedef logic [STATUS_W-1:0] result_status_type;

   localparam result_status_type ST_OK         = 3'd0;
   localparam result_status_type ST_EMPTY      = 3'd1;
   localparam result_status_type ST_TOKEN      = 3'd2;
   localparam result_status_type ST_LONE_MINUS = 3'd3;
   localparam result_status_type ST_DIGITS     = 3'd4;
   localparam result_status_type ST_RANGE      = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_KIND = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER   = 1'b1;

   localparam logic [KIND_W-1:0] KIND_REAL = 4'd0;
   localparam logic [KIND_W-1:0] KIND_S8   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_S16  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_S32  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_S64  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_U8   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_U16  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_U32  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_U64  = 4'd8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2e;

   localparam logic [KIND_W-1:0] KIND_RESET  = KIND_REAL;
   localparam logic [CHAR_W-1:0] DELIM_RESET = CHAR_PERIOD;

   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_INT   = 3'b010,
      PH_FRAC  = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic                 minus;
      logic                 sign_only;
      logic [VALUE_W-1:0]   int_acc;
      logic [VALUE_W-1:0]   frac_acc;
      logic [COUNT_W-1:0]   int_cnt;
      logic [COUNT_W-1:0]   frac_cnt;
      result_status_type    fail;
   } parse_state_type;

   localparam parse_state_type STATE_CLEAR = '{
      phase:     PH_START,
      minus:     1'b0,
      sign_only: 1'b0,
      int_acc:   '0,
      frac_acc:  '0,
      int_cnt:   '0,
      frac_cnt:  '0,
      fail:      ST_OK
   };

endpackage

// ----- rtl/adp_if.sv -----
// Valid/ready channel interfaces for the parser: character input, result
// output and register writes. Depends on adp_pkg.
interface adp_req_if;
   logic                         valid;
   logic                         ready;
   logic [adp_pkg::CHAR_W-1:0]   char_code;
   logic                         last;
   logic                         no_char;

   modport source (output valid, output char_code, output last, output no_char,
                   input ready);
   modport sink   (input valid, input char_code, input last, input no_char,
                   output ready);
endinterface

interface adp_rsp_if;
   logic                          valid;
   logic                          ready;
   adp_pkg::result_status_type    status_code;
   logic                          negative;
   logic [adp_pkg::VALUE_W-1:0]   integer_part;
   logic [adp_pkg::VALUE_W-1:0]   fraction_part;
   logic [adp_pkg::COUNT_W-1:0]   integer_digits;
   logic [adp_pkg::COUNT_W-1:0]   fraction_digits;

   modport source (output valid, output status_code, output negative,
                   output integer_part, output fraction_part,
                   output integer_digits, output fraction_digits, input ready);
   modport sink   (input valid, input status_code, input negative,
                   input integer_part, input fraction_part,
                   input integer_digits, input fraction_digits, output ready);
endinterface

interface adp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [adp_pkg::CSR_INDEX_W-1:0]   index;
   logic [adp_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ascii_decimal_number_parser.sv -----
// The block reads one decimal number per string, one character per transfer, and
// gives one result transfer when the transfer marked last has been taken. A new
// character is taken in every cycle but for the stall below: it sits in the input
// register while it is folded into the digit accumulator (one multiply-by-ten and
// add), the last character of a string also fills the end-of-string snapshot when
// it is taken, and the status and range check fill the result register from the
// snapshot once the output can take it. A result waiting on the output side stalls
// the input only when another string ends while the snapshot is still full. The
// user must write target_kind (index 0) and delimiter_char (index 1) only while
// the block is idle, which is not enforced. Depends on adp_pkg, adp_if and adp_accum.
module ascii_decimal_number_parser #(
   parameter int MAX_DIGITS = adp_pkg::MAX_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   adp_req_if.sink    req_bus,
   adp_rsp_if.source  rsp_bus,
   adp_csr_if.sink    csr_bus
);

   logic [adp_pkg::KIND_W-1:0]   kind_ff;
   logic [adp_pkg::CHAR_W-1:0]   delim_ff;

   logic                         in_valid_ff;
   logic [adp_pkg::CHAR_W-1:0]   in_char_ff;
   logic                         in_last_ff;
   logic                         in_none_ff;

   logic                         item_take;
   logic                         snap_valid;
   logic                         snap_take;
   adp_pkg::parse_state_type     snap;

   logic                         in_range;
   adp_pkg::result_status_type   status;
   logic [adp_pkg::VALUE_W-1:0]  acc;

   logic                         rsp_valid_ff;
   adp_pkg::result_status_type   status_ff;
   logic                         negative_ff;
   logic [adp_pkg::VALUE_W-1:0]  int_part_ff;
   logic [adp_pkg::VALUE_W-1:0]  frac_part_ff;
   logic [adp_pkg::COUNT_W-1:0]  int_digits_ff;
   logic [adp_pkg::COUNT_W-1:0]  frac_digits_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= adp_pkg::KIND_RESET;
         delim_ff <= adp_pkg::DELIM_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            adp_pkg::CSR_TARGET_KIND: kind_ff  <= csr_bus.data[adp_pkg::KIND_W-1:0];
            adp_pkg::CSR_DELIMITER:   delim_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   assign req_bus.ready = !in_valid_ff || item_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_char_ff <= req_bus.char_code;
         in_last_ff <= req_bus.last;
         in_none_ff <= req_bus.no_char;
      end
   end

   adp_accum #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_accum (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (in_valid_ff),
      .item_char      (in_char_ff),
      .item_last      (in_last_ff),
      .item_none      (in_none_ff),
      .target_kind    (kind_ff),
      .delimiter_char (delim_ff),
      .snap_take      (snap_take),
      .item_take      (item_take),
      .snap_valid     (snap_valid),
      .snap           (snap)
   );

   assign acc = snap.int_acc;

   always_comb begin
      case (kind_ff)
         adp_pkg::KIND_S8:  in_range = (acc[63:7] == '0) ||
                                       (snap.minus && acc == (adp_pkg::VALUE_W'(1) << 7));
         adp_pkg::KIND_S16: in_range = (acc[63:15] == '0) ||
                                       (snap.minus && acc == (adp_pkg::VALUE_W'(1) << 15));
         adp_pkg::KIND_S32: in_range = (acc[63:31] == '0) ||
                                       (snap.minus && acc == (adp_pkg::VALUE_W'(1) << 31));
         adp_pkg::KIND_S64: in_range = !acc[63] ||
                                       (snap.minus && acc == (adp_pkg::VALUE_W'(1) << 63));
         adp_pkg::KIND_U8:  in_range = (acc[63:8] == '0);
         adp_pkg::KIND_U16: in_range = (acc[63:16] == '0);
         adp_pkg::KIND_U32: in_range = (acc[63:32] == '0);
         default:           in_range = 1'b1;
      endcase
   end

   always_comb begin
      if (snap.phase == adp_pkg::PH_START) begin
         status = adp_pkg::ST_EMPTY;
      end else if (snap.fail != adp_pkg::ST_OK) begin
         status = snap.fail;
      end else if (snap.sign_only) begin
         status = adp_pkg::ST_LONE_MINUS;
      end else if (!in_range) begin
         status = adp_pkg::ST_RANGE;
      end else begin
         status = adp_pkg::ST_OK;
      end
   end

   assign snap_take = snap_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_bus.ready) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_take) begin
         status_ff <= status;
         if (status == adp_pkg::ST_OK) begin
            negative_ff    <= snap.minus;
            int_part_ff    <= snap.int_acc;
            frac_part_ff   <= snap.frac_acc;
            int_digits_ff  <= snap.int_cnt;
            frac_digits_ff <= snap.frac_cnt;
         end else begin
            negative_ff    <= 1'b0;
            int_part_ff    <= '0;
            frac_part_ff   <= '0;
            int_digits_ff  <= '0;
            frac_digits_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status_code     = status_ff;
   assign rsp_bus.negative        = negative_ff;
   assign rsp_bus.integer_part    = int_part_ff;
   assign rsp_bus.fraction_part   = frac_part_ff;
   assign rsp_bus.integer_digits  = int_digits_ff;
   assign rsp_bus.fraction_digits = frac_digits_ff;

endmodule

// ----- rtl/adp_accum.sv -----
// Per-string parse state: sign, phase, digit accumulators and counts, updated
// once per character, plus the end-of-string snapshot. Depends on adp_pkg.
module adp_accum #(
   parameter int MAX_DIGITS = adp_pkg::MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  logic [adp_pkg::CHAR_W-1:0]    item_char,
   input  logic                          item_last,
   input  logic                          item_none,
   input  logic [adp_pkg::KIND_W-1:0]    target_kind,
   input  logic [adp_pkg::CHAR_W-1:0]    delimiter_char,
   input  logic                          snap_take,
   output logic                          item_take,
   output logic                          snap_valid,
   output adp_pkg::parse_state_type      snap
);

   adp_pkg::parse_state_type     state_ff;
   adp_pkg::parse_state_type     state_in;
   adp_pkg::parse_state_type     snap_ff;
   logic                         snap_valid_ff;

   logic [adp_pkg::CHAR_W-1:0]   delim;
   logic                         is_real;
   logic                         sign_ok;
   logic                         is_digit;
   logic                         take;
   logic                         sign_used;
   logic                         frac_sel;
   logic [adp_pkg::VALUE_W-1:0]  acc_sel;
   logic [adp_pkg::COUNT_W-1:0]  cnt_sel;
   logic [adp_pkg::VALUE_W-1:0]  acc_next;
   logic [adp_pkg::COUNT_W-1:0]  cnt_next;
   logic                         cnt_full;

   assign delim    = (delimiter_char == '0) ? adp_pkg::CHAR_PERIOD : delimiter_char;
   assign is_real  = (target_kind == adp_pkg::KIND_REAL) ||
                     (target_kind > adp_pkg::KIND_U64);
   assign sign_ok  = is_real || (target_kind <= adp_pkg::KIND_S64);
   assign is_digit = (item_char >= adp_pkg::CHAR_ZERO) &&
                     (item_char <= adp_pkg::CHAR_NINE);
   assign take     = !item_none && (state_ff.fail != adp_pkg::ST_TOKEN);

   assign frac_sel = (state_ff.phase == adp_pkg::PH_FRAC);
   assign acc_sel  = frac_sel ? state_ff.frac_acc : state_ff.int_acc;
   assign cnt_sel  = frac_sel ? state_ff.frac_cnt : state_ff.int_cnt;
   assign acc_next = (acc_sel << 3) + (acc_sel << 1) +
                     adp_pkg::VALUE_W'(item_char[3:0]);
   assign cnt_next = adp_pkg::COUNT_W'(cnt_sel + 1'b1);
   assign cnt_full = (cnt_sel >= adp_pkg::COUNT_W'(MAX_DIGITS));

   always_comb begin
      state_in  = state_ff;
      sign_used = 1'b0;
      if (take) begin
         if (state_ff.phase == adp_pkg::PH_START) begin
            state_in.phase = adp_pkg::PH_INT;
            if (sign_ok && item_char == adp_pkg::CHAR_MINUS) begin
               state_in.minus     = 1'b1;
               state_in.sign_only = 1'b1;
               sign_used          = 1'b1;
            end else if (sign_ok && item_char == adp_pkg::CHAR_PLUS) begin
               sign_used = 1'b1;
            end
         end
         if (!sign_used) begin
            state_in.sign_only = 1'b0;
            if (is_digit) begin
               if (cnt_full) begin
                  if (state_ff.fail == adp_pkg::ST_OK) begin
                     state_in.fail = adp_pkg::ST_DIGITS;
                  end
               end else if (frac_sel) begin
                  state_in.frac_acc = acc_next;
                  state_in.frac_cnt = cnt_next;
               end else begin
                  state_in.int_acc = acc_next;
                  state_in.int_cnt = cnt_next;
               end
            end else if (!frac_sel && is_real && item_char == delim) begin
               state_in.phase = adp_pkg::PH_FRAC;
            end else begin
               state_in.fail = adp_pkg::ST_TOKEN;
            end
         end
      end
   end

   assign item_take = item_valid && (!item_last || !snap_valid_ff || snap_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= adp_pkg::STATE_CLEAR;
         snap_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            if (item_last) begin
               state_ff <= adp_pkg::STATE_CLEAR;
            end else begin
               state_ff <= state_in;
            end
         end
         if (item_take && item_last) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_take) begin
            snap_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && item_last) begin
         snap_ff <= state_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ----- rtl/adp_checker.sv -----
// Port-level checks on the parser's result channel, attached to the top level
// by the bind statement at the end of this file. Depends on adp_pkg.
module adp_checker #(
   parameter int MAX_DIGITS = adp_pkg::MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  adp_pkg::result_status_type    status_code,
   input  logic                          negative,
   input  logic [adp_pkg::VALUE_W-1:0]   integer_part,
   input  logic [adp_pkg::VALUE_W-1:0]   fraction_part,
   input  logic [adp_pkg::COUNT_W-1:0]   integer_digits,
   input  logic [adp_pkg::COUNT_W-1:0]   fraction_digits
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status_code) &&
      $stable(integer_part) && $stable(fraction_part))
      else $error("Result changed while the transfer was stalled.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_code != adp_pkg::ST_OK |->
      !negative && integer_part == '0 && fraction_part == '0 &&
      integer_digits == '0 && fraction_digits == '0)
      else $error("Failed result carries nonzero numeric fields.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status_code <= adp_pkg::ST_RANGE)
      else $error("Result status code out of range.");

   a_digit_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_code == adp_pkg::ST_OK |->
      integer_digits <= adp_pkg::COUNT_W'(MAX_DIGITS) &&
      fraction_digits <= adp_pkg::COUNT_W'(MAX_DIGITS))
      else $error("Successful result reports too many digits.");

   a_empty_parts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_code == adp_pkg::ST_OK |->
      (integer_digits != '0 || integer_part == '0) &&
      (fraction_digits != '0 || fraction_part == '0))
      else $error("A part without digits has a nonzero value.");

endmodule

bind ascii_decimal_number_parser adp_checker #(
   .MAX_DIGITS (MAX_DIGITS)
) u_adp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .status_code     (rsp_bus.status_code),
   .negative        (rsp_bus.negative),
   .integer_part    (rsp_bus.integer_part),
   .fraction_part   (rsp_bus.fraction_part),
   .integer_digits  (rsp_bus.integer_digits),
   .fraction_digits (rsp_bus.fraction_digits)
);
